// File: src/sdr_pkg.sv
package sdr_pkg;

    localparam int NODES      = 64;
    localparam int EDGES      = 128;
    localparam int VALUE_BITS = 48;
    localparam int NODE_AW    = $clog2(NODES);
    localparam int EDGE_AW    = $clog2(EDGES);
    localparam int NCNT_W     = NODE_AW + 1;
    localparam int ECNT_W     = EDGE_AW + 1;
    localparam int DATA_W     = 32;

    localparam logic [1:0] REQ_LOAD_BLOCK = 2'd0;
    localparam logic [1:0] REQ_LOAD_EDGE  = 2'd1;
    localparam logic [1:0] REQ_RUN        = 2'd2;
    localparam logic [1:0] REQ_READ       = 2'd3;

    localparam logic [1:0] CFG_MODE        = 2'd0;
    localparam logic [1:0] CFG_ENTRY_BLOCK = 2'd1;
    localparam logic [1:0] CFG_NODE_COUNT  = 2'd2;
    localparam logic [1:0] CFG_EDGE_COUNT  = 2'd3;

    localparam int CFG_DATA_W = 8;

    typedef struct packed {
        logic                 mode;
        logic [5:0]           entry_block;
        logic [6:0]           node_count;
        logic [7:0]           edge_count;
    } t_cfg;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [6:0]           slot;
        logic signed [31:0]   net_delta;
        logic signed [31:0]   peak;
        logic [5:0]           edge_source;
        logic [5:0]           edge_target;
    } t_req;

    typedef struct packed {
        logic                         kind;
        logic [5:0]                   node;
        logic signed [VALUE_BITS-1:0] value;
        logic                         reachable;
        logic                         converged;
        logic [6:0]                   rounds_used;
    } t_res;

    typedef struct packed {
        logic idle;
        logic res_vld;
    } t_eng_sts;

    // Saturating add of a stored value and a 32-bit block delta.
    function automatic logic signed [VALUE_BITS-1:0] sat_add(
        input logic signed [VALUE_BITS-1:0] a,
        input logic signed [DATA_W-1:0]     b
    );
        logic signed [VALUE_BITS:0] s;
        s = {a[VALUE_BITS-1], a} + {{(VALUE_BITS+1-DATA_W){b[DATA_W-1]}}, b};
        if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
            return s[VALUE_BITS] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                 : {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
        return s[VALUE_BITS-1:0];
    endfunction

    // Saturating negation; only the most negative value overflows.
    function automatic logic signed [VALUE_BITS-1:0] sat_neg(
        input logic signed [VALUE_BITS-1:0] a
    );
        logic signed [VALUE_BITS:0] s;
        s = -{a[VALUE_BITS-1], a};
        if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
            return {1'b0, {(VALUE_BITS-1){1'b1}}};
        end
        return s[VALUE_BITS-1:0];
    endfunction

endpackage

// File: src/sdr_req_if.sv
interface sdr_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [6:0]         slot;
    logic signed [31:0] net_delta;
    logic signed [31:0] peak;
    logic [5:0]         edge_source;
    logic [5:0]         edge_target;

    modport source (output valid, req_type, slot, net_delta, peak, edge_source, edge_target,
                    input ready);
    modport sink (input valid, req_type, slot, net_delta, peak, edge_source, edge_target,
                  output ready);
endinterface

// File: src/sdr_res_if.sv
interface sdr_res_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [5:0]         node;
    logic signed [47:0] value;
    logic               reachable;
    logic               converged;
    logic [6:0]         rounds_used;

    modport source (output valid, kind, node, value, reachable, converged, rounds_used,
                    input ready);
    modport sink (input valid, kind, node, value, reachable, converged, rounds_used,
                  output ready);
endinterface

// File: src/sdr_ram.sv
module sdr_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// File: src/sdr_engine.sv
module sdr_engine
    import sdr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_vld,
    input  t_req     i_req,
    input  t_cfg     i_cfg,
    output t_eng_sts o_sts,
    output t_res     o_res
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_BI_RD, S_BI_LAT, S_U_RD, S_U_LAT, S_E_RD, S_E_LAT,
        S_E_VAL, S_U_END, S_ROUND_END, S_F_RD, S_F_WR, S_REPORT
    } t_state;

    t_state                       r_state;
    logic [NODES-1:0]             r_rch;
    logic [NCNT_W-1:0]            r_u, r_n, r_rounds;
    logic [ECNT_W-1:0]            r_e, r_ne;
    logic                         r_back, r_changed, r_found, r_conv;
    logic [6:0]                   r_slot;
    logic [NODE_AW-1:0]           r_to;
    logic signed [VALUE_BITS-1:0] r_after, r_best, r_valu;
    logic signed [DATA_W-1:0]     r_net;
    logic                         r_res_vld;
    t_res                         r_res;

    logic                         node_we, edge_we, val_we;
    logic [NODE_AW-1:0]           node_waddr, val_waddr, val_raddr;
    logic [2*DATA_W-1:0]          node_wdata, node_rdata;
    logic [2*NODE_AW-1:0]         edge_wdata, edge_rdata;
    logic signed [VALUE_BITS-1:0] val_wdata, val_rdata;
    logic [NODE_AW-1:0]           e_from, e_to;
    logic signed [DATA_W-1:0]     rd_net, rd_peak;
    logic signed [VALUE_BITS-1:0] cand;
    logic [NCNT_W-1:0]            n_n, u_inc, rounds_inc;
    logic [ECNT_W-1:0]            n_ne, e_inc;
    logic                         entry_in;

    assign {rd_net, rd_peak} = node_rdata;
    assign {e_from, e_to}    = edge_rdata;
    assign cand       = sat_add(val_rdata, r_net);
    assign u_inc      = r_u + 1'b1;
    assign e_inc      = r_e + 1'b1;
    assign rounds_inc = r_rounds + 1'b1;
    assign n_n  = (i_cfg.node_count > NCNT_W'(NODES)) ? NCNT_W'(NODES) : i_cfg.node_count;
    assign n_ne = (i_cfg.edge_count > ECNT_W'(EDGES)) ? ECNT_W'(EDGES) : i_cfg.edge_count;
    assign entry_in = {1'b0, i_cfg.entry_block} < n_n;

    assign node_we    = i_req_vld && i_req.req_type == REQ_LOAD_BLOCK && !i_req.slot[6];
    assign node_waddr = i_req.slot[NODE_AW-1:0];
    assign node_wdata = {i_req.net_delta, i_req.peak};
    assign edge_we    = i_req_vld && i_req.req_type == REQ_LOAD_EDGE;
    assign edge_wdata = {i_req.edge_source, i_req.edge_target};

    always_comb begin
        val_we    = 1'b0;
        val_waddr = r_u[NODE_AW-1:0];
        val_wdata = '0;
        val_raddr = r_u[NODE_AW-1:0];
        case (r_state)
            S_IDLE: begin
                val_raddr = i_req.slot[NODE_AW-1:0];
                val_waddr = i_cfg.entry_block;
                val_we    = i_req_vld && i_req.req_type == REQ_RUN && !i_cfg.mode && entry_in;
            end
            S_BI_LAT: begin
                val_we    = 1'b1;
                val_wdata = {{(VALUE_BITS-DATA_W){rd_peak[DATA_W-1]}}, rd_peak};
            end
            S_E_LAT: val_raddr = e_to;
            S_E_VAL: begin
                val_waddr = r_to;
                val_wdata = r_after;
                val_we    = !r_back && (!r_rch[r_to] || r_after < val_rdata);
            end
            S_U_END: begin
                val_wdata = r_best;
                val_we    = r_back && r_found && r_best < r_valu;
            end
            S_F_WR: begin
                val_wdata = sat_neg(val_rdata);
                val_we    = 1'b1;
            end
            default: ;
        endcase
    end

    sdr_ram #(.DEPTH(NODES), .WIDTH(2*DATA_W)) u_node_ram (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(r_u[NODE_AW-1:0]), .o_rdata(node_rdata)
    );

    sdr_ram #(.DEPTH(EDGES), .WIDTH(2*NODE_AW)) u_edge_ram (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(i_req.slot[EDGE_AW-1:0]),
        .i_wdata(edge_wdata), .i_raddr(r_e[EDGE_AW-1:0]), .o_rdata(edge_rdata)
    );

    sdr_ram #(.DEPTH(NODES), .WIDTH(VALUE_BITS)) u_val_ram (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_waddr), .i_wdata(val_wdata),
        .i_raddr(val_raddr), .o_rdata(val_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rch     <= '0;
            r_conv    <= 1'b0;
            r_rounds  <= '0;
            r_n       <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_vld && i_req.req_type == REQ_READ) begin
                        r_slot  <= i_req.slot;
                        r_state <= S_RD;
                    end else if (i_req_vld && i_req.req_type == REQ_RUN) begin
                        r_n       <= n_n;
                        r_ne      <= n_ne;
                        r_back    <= i_cfg.mode;
                        r_u       <= '0;
                        r_rounds  <= '0;
                        r_changed <= 1'b0;
                        if (n_n == '0) begin
                            r_rch   <= '0;
                            r_conv  <= 1'b1;
                            r_state <= S_REPORT;
                        end else if (i_cfg.mode) begin
                            r_rch   <= '0;
                            r_state <= S_BI_RD;
                        end else begin
                            // Only the entry block starts out reached.
                            r_rch   <= entry_in
                                ? ({{(NODES-1){1'b0}}, 1'b1} << i_cfg.entry_block) : '0;
                            r_state <= S_U_RD;
                        end
                    end
                end
                S_RD: begin
                    r_res_vld       <= 1'b1;
                    r_res.kind      <= 1'b1;
                    r_res.node      <= r_slot[5:0];
                    r_res.reachable <= !r_slot[6] && r_rch[r_slot[5:0]];
                    r_res.value     <= (!r_slot[6] && r_rch[r_slot[5:0]]) ? val_rdata : '0;
                    r_res.converged   <= r_conv;
                    r_res.rounds_used <= r_rounds;
                    r_state <= S_IDLE;
                end
                S_BI_RD: r_state <= S_BI_LAT;
                S_BI_LAT: begin
                    r_rch[r_u[NODE_AW-1:0]] <= 1'b1;
                    if (u_inc == r_n) begin
                        r_u     <= '0;
                        r_state <= S_U_RD;
                    end else begin
                        r_u     <= u_inc;
                        r_state <= S_BI_RD;
                    end
                end
                S_U_RD: r_state <= S_U_LAT;
                S_U_LAT: begin
                    r_net   <= rd_net;
                    r_valu  <= val_rdata;
                    r_after <= sat_add(val_rdata, rd_net);
                    r_found <= 1'b0;
                    r_e     <= '0;
                    if (!r_back && !r_rch[r_u[NODE_AW-1:0]]) begin
                        r_state <= S_U_END;
                    end else if (r_ne == '0) begin
                        r_state <= S_U_END;
                    end else begin
                        r_state <= S_E_RD;
                    end
                end
                S_E_RD: r_state <= S_E_LAT;
                S_E_LAT: begin
                    r_to <= e_to;
                    if (e_from == r_u[NODE_AW-1:0] && {1'b0, e_to} < r_n) begin
                        r_state <= S_E_VAL;
                    end else if (e_inc == r_ne) begin
                        r_state <= S_U_END;
                    end else begin
                        r_e     <= e_inc;
                        r_state <= S_E_RD;
                    end
                end
                S_E_VAL: begin
                    if (val_we) begin
                        r_rch[r_to] <= 1'b1;
                        r_changed   <= 1'b1;
                    end
                    if (r_back && (!r_found || cand < r_best)) begin
                        r_best  <= cand;
                        r_found <= 1'b1;
                    end
                    if (e_inc == r_ne) begin
                        r_state <= S_U_END;
                    end else begin
                        r_e     <= e_inc;
                        r_state <= S_E_RD;
                    end
                end
                S_U_END: begin
                    if (val_we) begin
                        r_changed <= 1'b1;
                    end
                    if (u_inc == r_n) begin
                        r_state <= S_ROUND_END;
                    end else begin
                        r_u     <= u_inc;
                        r_state <= S_U_RD;
                    end
                end
                S_ROUND_END: begin
                    r_rounds  <= rounds_inc;
                    r_u       <= '0;
                    r_changed <= 1'b0;
                    if (!r_changed || rounds_inc == r_n) begin
                        r_conv  <= !r_changed;
                        r_state <= r_back ? S_F_RD : S_REPORT;
                    end else begin
                        r_state <= S_U_RD;
                    end
                end
                S_F_RD: r_state <= S_F_WR;
                S_F_WR: begin
                    if (u_inc == r_n) begin
                        r_state <= S_REPORT;
                    end else begin
                        r_u     <= u_inc;
                        r_state <= S_F_RD;
                    end
                end
                S_REPORT: begin
                    r_res_vld         <= 1'b1;
                    r_res.kind        <= 1'b0;
                    r_res.node        <= '0;
                    r_res.value       <= '0;
                    r_res.reachable   <= 1'b0;
                    r_res.converged   <= r_conv;
                    r_res.rounds_used <= r_rounds;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_sts.idle    = r_state == S_IDLE;
    assign o_sts.res_vld = r_res_vld;
    assign o_res         = r_res;

    a_req_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_vld |-> r_state == S_IDLE)
        else $error("request taken while a run or read is in progress");

    a_res_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> r_state == S_IDLE)
        else $error("result issued while engine still busy");

    a_rounds_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rounds <= r_n)
        else $error("round count exceeds node count");

    a_run_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPORT) |=> r_res_vld && !r_res.kind)
        else $error("run finished without a report");
endmodule

// File: src/stack_depth_relaxation_core.sv
// Stack depth relaxation core. Software loads each block's net stack change and lowest
// in-block change (load block requests), then the successor edges (load edge requests),
// sets mode, entry_block, node_count and edge_count through the configuration port, and
// issues a run request. The run relaxes offsets in place, blocks in ascending order, in
// rounds, and stops after a round with no update or after node_count rounds; it answers
// with one report carrying the converged flag and the round count. A read request then
// returns one block's value: the least entry offset with a reachable flag in forward
// mode, or the greatest stack depth in backward mode. Loads produce no result. A run
// walks every edge of the edge memory for each block of each round, and an edge that
// leaves the block costs a further value lookup; a forward block not yet reached skips
// its edges. Backward mode adds a pass over the blocks to copy the peaks in and one to
// negate the results. Run time is set by the single read port of the value memory and
// the edge memory, which are walked one entry per access with no overlap. A new
// request is taken only while the engine is idle, no result is being handed over and
// the result register is empty.
module stack_depth_relaxation_core
    import sdr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sdr_req_if.sink               i_req,
    sdr_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_cfg     r_cfg;
    t_req     req;
    t_res     eng_res;
    t_eng_sts eng_sts;
    logic     r_out_vld;
    t_res     r_out;
    logic     req_take;

    // The user must write configuration only while the block is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= 1'b0;
            r_cfg.entry_block <= '0;
            r_cfg.node_count  <= 7'd1;
            r_cfg.edge_count  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:        r_cfg.mode        <= i_cfg_data[0];
                CFG_ENTRY_BLOCK: r_cfg.entry_block <= i_cfg_data[5:0];
                CFG_NODE_COUNT:  r_cfg.node_count  <= i_cfg_data[6:0];
                CFG_EDGE_COUNT:  r_cfg.edge_count  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // The engine works on one request at a time; the result register keeps a
    // finished answer until the sink takes it. In the cycle the engine hands its
    // answer over it is already idle, so that cycle is held off as well.
    assign i_req.ready = eng_sts.idle && !eng_sts.res_vld && !r_out_vld;
    assign req_take    = i_req.valid && i_req.ready;

    assign req.req_type    = i_req.req_type;
    assign req.slot        = i_req.slot;
    assign req.net_delta   = i_req.net_delta;
    assign req.peak        = i_req.peak;
    assign req.edge_source = i_req.edge_source;
    assign req.edge_target = i_req.edge_target;

    sdr_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req_vld (req_take),
        .i_req     (req),
        .i_cfg     (r_cfg),
        .o_sts     (eng_sts),
        .o_res     (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (eng_sts.res_vld) begin
                r_out_vld <= 1'b1;
                r_out     <= eng_res;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.kind        = r_out.kind;
    assign o_res.node        = r_out.node;
    assign o_res.value       = r_out.value;
    assign o_res.reachable   = r_out.reachable;
    assign o_res.converged   = r_out.converged;
    assign o_res.rounds_used = r_out.rounds_used;

    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_sts.res_vld |-> !r_out_vld)
        else $error("engine result would overwrite a pending result");

    a_busy_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !eng_sts.idle |-> !i_req.ready)
        else $error("request channel open while engine busy");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_sts.res_vld |=> r_out_vld)
        else $error("engine result not captured");
endmodule

// File: sim/sdr_offset_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and configuration ports, keeps its own copy of the
// block stores and relaxes the graph itself on every run request.
module sdr_offset_checker
    import sdr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    sdr_req_if              req,
    sdr_res_if              res,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int              o_errors,
    output int              o_pending
);

    localparam longint VMAX = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;

    logic               cfg_mode;
    logic [5:0]         cfg_entry;
    logic [6:0]         cfg_nodes;
    logic [7:0]         cfg_edges;
    logic signed [31:0] net_mem [NODES];
    logic signed [31:0] peak_mem [NODES];
    logic [5:0]         edge_from [EDGES];
    logic [5:0]         edge_to [EDGES];
    longint             offset_val [NODES];
    bit                 reached [NODES];
    bit                 run_converged;
    logic [6:0]         run_rounds;
    t_res               expected_q [$];

    function automatic longint clamp_value(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    function automatic void relax_graph();
        int     n;
        int     ne;
        int     rounds;
        int     v;
        bit     conv;
        bit     changed;
        bit     found;
        longint after;
        longint best;
        longint cand;
        n = (cfg_nodes > NODES) ? NODES : cfg_nodes;
        ne = (cfg_edges > EDGES) ? EDGES : cfg_edges;
        conv = (n == 0);
        rounds = 0;
        for (int i = 0; i < NODES; i++) begin
            offset_val[i] = 0;
            reached[i] = 1'b0;
        end
        if (cfg_mode) begin
            for (int i = 0; i < n; i++) begin
                offset_val[i] = clamp_value(longint'(peak_mem[i]));
                reached[i] = 1'b1;
            end
        end else if (cfg_entry < n) begin
            reached[cfg_entry] = 1'b1;
        end
        for (int r = 0; r < n; r++) begin
            changed = 1'b0;
            for (int u = 0; u < n; u++) begin
                if (!cfg_mode) begin
                    if (!reached[u]) continue;
                    after = clamp_value(offset_val[u] + longint'(net_mem[u]));
                    for (int e = 0; e < ne; e++) begin
                        v = edge_to[e];
                        if (edge_from[e] != u || v >= n) continue;
                        if (!reached[v] || after < offset_val[v]) begin
                            offset_val[v] = after;
                            reached[v] = 1'b1;
                            changed = 1'b1;
                        end
                    end
                end else begin
                    found = 1'b0;
                    best = 0;
                    for (int e = 0; e < ne; e++) begin
                        v = edge_to[e];
                        if (edge_from[e] != u || v >= n) continue;
                        cand = clamp_value(longint'(net_mem[u]) + offset_val[v]);
                        if (!found || cand < best) begin
                            best = cand;
                            found = 1'b1;
                        end
                    end
                    if (found && best < offset_val[u]) begin
                        offset_val[u] = best;
                        changed = 1'b1;
                    end
                end
            end
            rounds++;
            if (!changed) begin
                conv = 1'b1;
                break;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (cfg_mode) offset_val[i] = clamp_value(-offset_val[i]);
            else if (!reached[i]) offset_val[i] = 0;
        end
        run_converged = conv;
        run_rounds = rounds[6:0];
    endfunction

    task automatic report(string field, longint exp_v, longint act_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_res exp_r;
        t_res got;
        if (!i_rst_n) begin
            cfg_mode <= 1'b0;
            cfg_entry <= '0;
            cfg_nodes <= 7'd1;
            cfg_edges <= '0;
            for (int i = 0; i < NODES; i++) begin
                offset_val[i] = 0;
                reached[i] = 1'b0;
            end
            run_converged = 1'b0;
            run_rounds = '0;
            expected_q.delete();
            o_errors = 0;
        end else begin
            // Results are checked before this edge's request is predicted.
            if (res.valid && res.ready) begin
                got.kind = res.kind;
                got.node = res.node;
                got.value = res.value;
                got.reachable = res.reachable;
                got.converged = res.converged;
                got.rounds_used = res.rounds_used;
                if (expected_q.size() == 0) begin
                    $display("%0t: result with none expected, actual kind %0d node %0d",
                             $time, got.kind, got.node);
                    o_errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.kind !== exp_r.kind) report("kind", exp_r.kind, got.kind);
                    if (got.node !== exp_r.node) report("node", exp_r.node, got.node);
                    if (got.value !== exp_r.value)
                        report("value", exp_r.value, got.value);
                    if (got.reachable !== exp_r.reachable)
                        report("reachable", exp_r.reachable, got.reachable);
                    if (got.converged !== exp_r.converged)
                        report("converged", exp_r.converged, got.converged);
                    if (got.rounds_used !== exp_r.rounds_used)
                        report("rounds_used", exp_r.rounds_used, got.rounds_used);
                end
            end
            if (req.valid && req.ready) begin
                case (req.req_type)
                    REQ_LOAD_BLOCK: begin
                        if (req.slot < NODES) begin
                            net_mem[req.slot] = req.net_delta;
                            peak_mem[req.slot] = req.peak;
                        end
                    end
                    REQ_LOAD_EDGE: begin
                        if (req.slot < EDGES) begin
                            edge_from[req.slot] = req.edge_source;
                            edge_to[req.slot] = req.edge_target;
                        end
                    end
                    default: begin
                        exp_r = '0;
                        if (req.req_type == REQ_RUN) begin
                            relax_graph();
                        end else begin
                            exp_r.kind = 1'b1;
                            exp_r.node = req.slot[5:0];
                            if (req.slot < NODES) begin
                                exp_r.value = offset_val[req.slot][VALUE_BITS-1:0];
                                exp_r.reachable = reached[req.slot];
                            end
                        end
                        exp_r.converged = run_converged;
                        exp_r.rounds_used = run_rounds;
                        expected_q.insert(expected_q.size(), exp_r);
                    end
                endcase
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:        cfg_mode <= i_cfg_data[0];
                    CFG_ENTRY_BLOCK: cfg_entry <= i_cfg_data[5:0];
                    CFG_NODE_COUNT:  cfg_nodes <= i_cfg_data[6:0];
                    CFG_EDGE_COUNT:  cfg_edges <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// File: sim/stack_depth_relaxation_core_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the stack depth relaxation core. The checker beside the
// block predicts every result; this module only makes requests and configuration writes.
module stack_depth_relaxation_core_test;
    import sdr_pkg::*;

    // Edge shapes: free random edges, or ordered chains that converge in few rounds
    // (targets above the source for forward runs, below it for backward runs).
    localparam int SHAPE_RANDOM   = 0;
    localparam int SHAPE_ASCEND   = 1;
    localparam int SHAPE_DESCEND  = 2;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_cfg_we = 0;
    logic [1:0]            i_cfg_idx = CFG_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    errors;
    int                    pending;
    int                    send_idle = 0;
    int                    recv_idle = 0;

    sdr_req_if req_ch();
    sdr_res_if res_ch();

    stack_depth_relaxation_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    sdr_offset_checker offset_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // The result side stalls at random at each falling edge.
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Hard stop; the slowest correct run stays well below this.
    initial begin
        #10_000_000;
        $display("stack_depth_relaxation_core_test: errors");
        $finish;
    end

    // Sends one request. valid stays high afterwards so that back-to-back requests
    // need no gap; the sender's idle cycles are inserted before the request instead.
    task automatic send_req(logic [1:0] kind, logic [6:0] slot, logic signed [31:0] net,
                            logic signed [31:0] pk, logic [5:0] src, logic [5:0] dst);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle) begin
            req_ch.valid <= 0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.req_type <= kind;
        req_ch.slot <= slot;
        req_ch.net_delta <= net;
        req_ch.peak <= pk;
        req_ch.edge_source <= src;
        req_ch.edge_target <= dst;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Drops valid and waits until every expected result has come back, plus a margin
    // for a load that may still be in flight.
    task automatic settle();
        @(negedge i_clk);
        req_ch.valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic configure(logic mode, logic [7:0] entry, logic [7:0] nodes,
                             logic [7:0] edges);
        settle();
        write_reg(CFG_MODE, {7'd0, mode});
        write_reg(CFG_ENTRY_BLOCK, entry);
        write_reg(CFG_NODE_COUNT, nodes);
        write_reg(CFG_EDGE_COUNT, edges);
    endtask

    // Mostly small deltas so that relaxation makes real decisions, with the extremes
    // and full-range values mixed in.
    function automatic logic signed [31:0] pick_net();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom();
            default: return int'($urandom_range(0, 200)) - 100;
        endcase
    endfunction

    // Peaks are never positive.
    function automatic logic signed [31:0] pick_peak();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 0;
            2: return {1'b1, 31'($urandom())};
            default: return -int'($urandom_range(0, 300));
        endcase
    endfunction

    task automatic load_block(int slot);
        send_req(REQ_LOAD_BLOCK, slot[6:0], pick_net(), pick_peak(),
                 6'($urandom()), 6'($urandom()));
    endtask

    task automatic load_edge(int slot, int n, int shape);
        int src;
        int dst;
        src = $urandom_range(0, n - 1);
        dst = $urandom_range(0, n - 1);
        if (shape == SHAPE_ASCEND) begin
            src = slot % (n - 1);
            dst = $urandom_range(src + 1, n - 1);
        end else if (shape == SHAPE_DESCEND) begin
            src = 1 + slot % (n - 1);
            dst = $urandom_range(0, src - 1);
        end else if ($urandom_range(0, 9) == 0) begin
            // An edge to or from a block past the node count is skipped by a run.
            if ($urandom_range(0, 1)) dst = $urandom_range(n, 63);
            else src = $urandom_range(n, 63);
        end
        send_req(REQ_LOAD_EDGE, slot[6:0], $urandom(), $urandom(), src[5:0], dst[5:0]);
    endtask

    // Every block and edge that a run may touch is written before the first run.
    task automatic load_graph(int n, int ne, int shape);
        for (int i = 0; i < n; i++) load_block(i);
        for (int e = 0; e < ne; e++) load_edge(e, n, shape);
    endtask

    task automatic read_node(int slot);
        send_req(REQ_READ, slot[6:0], $urandom(), $urandom(),
                 6'($urandom()), 6'($urandom()));
    endtask

    task automatic start_run();
        send_req(REQ_RUN, 7'($urandom()), $urandom(), $urandom(),
                 6'($urandom()), 6'($urandom()));
    endtask

    // A phase: configure, load the graph and run it, then a random mix of reruns, reloads
    // and reads, ending with a run and a read of each of the first eight blocks in use.
    task automatic graph_phase(logic mode, int entry, int ncfg, int ecfg, int shape,
                               int mix_items);
        int n;
        int ne;
        int pick;
        n = (ncfg > NODES) ? NODES : ncfg;
        ne = (ecfg > EDGES) ? EDGES : ecfg;
        configure(mode, entry[7:0], ncfg[7:0], ecfg[7:0]);
        load_graph(n, ne, shape);
        start_run();
        for (int k = 0; k < mix_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) start_run();
            else if (pick < 25) load_block($urandom_range(0, n - 1));
            else if (pick < 30) load_block($urandom_range(NODES, 127));
            else if (pick < 40 && ne > 0) load_edge($urandom_range(0, ne - 1), n, shape);
            else if (pick < 45) read_node($urandom_range(NODES, 127));
            else read_node($urandom_range(0, n - 1));
        end
        start_run();
        for (int i = 0; i < n && i < 8; i++) read_node(i);
    endtask

    initial begin
        int n;
        req_ch.valid = 0;
        req_ch.req_type = REQ_LOAD_BLOCK;
        req_ch.slot = '0;
        req_ch.net_delta = '0;
        req_ch.peak = '0;
        req_ch.edge_source = '0;
        req_ch.edge_target = '0;
        res_ch.ready = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Reset state is visible through reads before any run.
        read_node(0);
        read_node(127);
        // Default configuration: one block, no edges. Block loads past the store
        // are ignored.
        send_req(REQ_LOAD_BLOCK, 7'd0, 32'sh7fff_ffff, 32'sh8000_0000, 6'd0, 6'd0);
        send_req(REQ_LOAD_BLOCK, 7'd100, 32'sh8000_0000, 32'sh0, 6'd63, 6'd63);
        start_run();
        read_node(0);
        read_node(64);
        // Zero node count: the run clears everything and converges at once.
        configure(1'b1, 8'd0, 8'd0, 8'd0);
        start_run();
        read_node(0);
        // Entry block past the node count reaches nothing.
        configure(1'b0, 8'd63, 8'd4, 8'd4);
        load_graph(4, 4, SHAPE_RANDOM);
        start_run();
        read_node(0);
        read_node(3);

        // Three idle settings: receiver idles more, sender idles more, no idling.
        for (int pass = 0; pass < 3; pass++) begin
            send_idle = (pass == 0) ? 23 : (pass == 1) ? 56 : 0;
            recv_idle = (pass == 0) ? 56 : (pass == 1) ? 23 : 0;
            n = $urandom_range(2, 5);
            graph_phase(1'b0, $urandom_range(0, n - 1), n, $urandom_range(1, 6),
                        SHAPE_RANDOM, 3);
            n = $urandom_range(2, 5);
            graph_phase(1'b1, $urandom_range(0, 63), n, $urandom_range(0, 6),
                        SHAPE_RANDOM, 3);
        end

        settle();
        repeat (50) @(negedge i_clk);
        if (errors == 0) begin
            $display("stack_depth_relaxation_core_test: clean");
        end else begin
            $display("stack_depth_relaxation_core_test: errors");
        end
        $finish;
    end

endmodule
